// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, reset-qualified.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/mcfp_pkg.sv =====
// Package for the motor command frame packer: constants, register indexes, types.
// No dependencies.
`timescale 1ns / 1ps

package mcfp_pkg;

    typedef logic signed [31:0] q16_t;

    localparam int NUM_CH         = 5;
    localparam int NUM_CFG        = 8;
    localparam int POS_BITS       = 16;
    localparam int GAIN_BITS      = 12;
    localparam int QUO_W          = 16;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
    localparam int REM_W          = 48;
    localparam int ADDR_W         = 5;

    // Channel indexes in input order
    localparam int CH_POS = 0;
    localparam int CH_VEL = 1;
    localparam int CH_TRQ = 2;
    localparam int CH_KP  = 3;
    localparam int CH_KD  = 4;

    // Register indexes
    localparam logic [2:0] REG_POSITION_MIN  = 3'd0;
    localparam logic [2:0] REG_POSITION_MAX  = 3'd1;
    localparam logic [2:0] REG_VELOCITY_MIN  = 3'd2;
    localparam logic [2:0] REG_VELOCITY_MAX  = 3'd3;
    localparam logic [2:0] REG_TORQUE_MIN    = 3'd4;
    localparam logic [2:0] REG_TORQUE_MAX    = 3'd5;
    localparam logic [2:0] REG_STIFFNESS_MAX = 3'd6;
    localparam logic [2:0] REG_DAMPING_MAX   = 3'd7;

    localparam q16_t STIFFNESS_MIN = 32'sd0;
    localparam q16_t DAMPING_MIN   = 32'sd0;

    localparam q16_t CFG_RESET [NUM_CFG] = '{
        -32'sd819200, 32'sd819200, -32'sd4259840, 32'sd4259840,
        -32'sd1179648, 32'sd1179648, 32'sd32768000, 32'sd327680
    };

endpackage

// ===== src/motor_command_frame_packer.sv =====
// Motor command frame packer top level: clamp, scale and divide five Q16.16 values.
// Depends on mcfp_pkg.
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    s_tdata  160b : five Q16.16 command values
//  m_*       out        m_tvalid / m_tready    m_tdata   64b : packed command frame
//  apb       in/out     psel & penable         paddr/pwdata/prdata : eight limit registers
//
//  One command per cycle while the output register is empty or taken; path to m_tvalid:
//  clamp stage, scale stage, eight divider stages (two quotient bits each), output register.
//  The 16-step restoring divider per value sets the depth.
//  All stages advance together whenever the output register is empty or taken.
//  rst_n clears valid bits and loads the limit registers with their reset values.
module motor_command_frame_packer
    import mcfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [31:0] position, [63:32] velocity, [95:64] torque,
    // [127:96] stiffness_gain, [159:128] damping_gain
    input  logic [159:0]      s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [63:0] frame
    output logic [63:0]       m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ---------------------------------------------------------------- config
    q16_t cfg_reg [NUM_CFG];
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = cfg_reg[paddr[ADDR_W-1:2]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_wr)
        begin
            cfg_reg[paddr[ADDR_W-1:2]] <= pwdata;
        end
    end

    // ---------------------------------------------------------------- pipeline control
    logic advance;
    logic valid0_reg;
    logic vdiv_reg [DIV_STAGES+1];
    logic out_valid_reg;

    // Advance everything when the output slot is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                vdiv_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid0_reg  <= s_tvalid;
            vdiv_reg[0] <= valid0_reg;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                vdiv_reg[k] <= vdiv_reg[k-1];
            end
            out_valid_reg <= vdiv_reg[DIV_STAGES];
        end
    end

    // ---------------------------------------------------------------- stage 0: clamp
    logic [31:0] d0_next    [NUM_CH];
    logic [31:0] span0_next [NUM_CH];
    logic        ok0_next   [NUM_CH];
    logic [31:0] d0_reg     [NUM_CH];
    logic [31:0] span0_reg  [NUM_CH];
    logic        ok0_reg    [NUM_CH];

    always_comb
    begin
        logic signed [33:0] lo;
        logic signed [33:0] hi;
        logic signed [33:0] x;
        logic signed [33:0] span;
        logic signed [33:0] xc;
        logic signed [33:0] d;
        for (int c = 0; c < NUM_CH; c++)
        begin
            case (c)
                CH_POS:
                begin
                    lo = 34'(cfg_reg[REG_POSITION_MIN]);
                    hi = 34'(cfg_reg[REG_POSITION_MAX]);
                end
                CH_VEL:
                begin
                    lo = 34'(cfg_reg[REG_VELOCITY_MIN]);
                    hi = 34'(cfg_reg[REG_VELOCITY_MAX]);
                end
                CH_TRQ:
                begin
                    lo = 34'(cfg_reg[REG_TORQUE_MIN]);
                    hi = 34'(cfg_reg[REG_TORQUE_MAX]);
                end
                CH_KP:
                begin
                    lo = 34'(STIFFNESS_MIN);
                    hi = 34'(cfg_reg[REG_STIFFNESS_MAX]);
                end
                default:
                begin
                    lo = 34'(DAMPING_MIN);
                    hi = 34'(cfg_reg[REG_DAMPING_MAX]);
                end
            endcase
            x    = 34'(signed'(s_tdata[32*c +: 32]));
            span = hi - lo;
            // Clamp into [lo, hi]
            if (x < lo)
            begin
                xc = lo;
            end
            else if (x > hi)
            begin
                xc = hi;
            end
            else
            begin
                xc = x;
            end
            d             = xc - lo;
            ok0_next[c]   = (span > 34'sd0);
            d0_next[c]    = d[31:0];
            span0_next[c] = span[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d0_reg    <= d0_next;
            span0_reg <= span0_next;
            ok0_reg   <= ok0_next;
        end
    end

    // ---------------------------------------------------------------- stage 1: scale
    logic [REM_W-1:0] rem_reg  [DIV_STAGES+1][NUM_CH];
    logic [31:0]      span_reg [DIV_STAGES+1][NUM_CH];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES+1][NUM_CH];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                // d * (2^bits - 1) as a shift and subtract; empty range drops to zero
                if (!ok0_reg[c])
                begin
                    rem_reg[0][c]  <= '0;
                    span_reg[0][c] <= '1;
                end
                else if (c == CH_POS)
                begin
                    rem_reg[0][c]  <= {d0_reg[c], {POS_BITS{1'b0}}} - REM_W'(d0_reg[c]);
                    span_reg[0][c] <= span0_reg[c];
                end
                else
                begin
                    rem_reg[0][c]  <= REM_W'({d0_reg[c], {GAIN_BITS{1'b0}}})
                                      - REM_W'(d0_reg[c]);
                    span_reg[0][c] <= span0_reg[c];
                end
                quo_reg[0][c] <= '0;
            end
        end
    end

    // ---------------------------------------------------------------- divider stages
    genvar gk;
    generate
        for (gk = 0; gk < DIV_STAGES; gk++)
        begin : g_div
            logic [REM_W-1:0] rem_next [NUM_CH];
            logic [QUO_W-1:0] quo_next [NUM_CH];

            always_comb
            begin
                logic [REM_W-1:0] r;
                logic [REM_W-1:0] sh;
                logic [QUO_W-1:0] q;
                int               bidx;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    r = rem_reg[gk][c];
                    q = quo_reg[gk][c];
                    for (int j = 0; j < BITS_PER_STAGE; j++)
                    begin
                        bidx = QUO_W - 1 - BITS_PER_STAGE * gk - j;
                        sh   = REM_W'(span_reg[gk][c]) << bidx;
                        if (r >= sh)
                        begin
                            r       = r - sh;
                            q[bidx] = 1'b1;
                        end
                    end
                    rem_next[c] = r;
                    quo_next[c] = q;
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[gk+1]  <= rem_next;
                    quo_reg[gk+1]  <= quo_next;
                    span_reg[gk+1] <= span_reg[gk];
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------- output register
    logic [63:0] frame_reg;
    logic [63:0] frame_next;

    always_comb
    begin
        frame_next = {quo_reg[DIV_STAGES][CH_POS][POS_BITS-1:0],
                      quo_reg[DIV_STAGES][CH_VEL][GAIN_BITS-1:0],
                      quo_reg[DIV_STAGES][CH_KP][GAIN_BITS-1:0],
                      quo_reg[DIV_STAGES][CH_KD][GAIN_BITS-1:0],
                      quo_reg[DIV_STAGES][CH_TRQ][GAIN_BITS-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            frame_reg <= frame_next;
        end
    end

    assign m_tdata = frame_reg;

endmodule

// ===== src/mcfp_checker.sv =====
// Port-level checker for the motor command frame packer, bound to the top level.
// Depends on mcfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcfp_checker
    import mcfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        pready
);

    // Hold a stalled result
    `ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Input side never waits on an empty output slot
    `ASSERT_IMP(a_ready_free, clk, rst_n, !m_tvalid, s_tready)
    // Input side stalls only behind a stalled result
    `ASSERT_IMP(a_ready_stall, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    // Register port never inserts wait states
    `ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)

endmodule

bind motor_command_frame_packer mcfp_checker u_mcfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// ===== tb/sv/tb_motor_command_frame_packer.sv =====
// Testbench for the motor command frame packer: drives commands and limit-register
// writes, predicts each packed frame and checks it. Depends on mcfp_pkg and the block.
`timescale 1ns / 1ps

module tb_motor_command_frame_packer
    import mcfp_pkg::*;
();

    typedef struct packed {
        q16_t damping_gain;
        q16_t stiffness_gain;
        q16_t torque;
        q16_t velocity;
        q16_t position;
    } command_t;

    localparam int LATENCY     = 11;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [159:0]      s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [63:0]       m_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    motor_command_frame_packer uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Limit registers as the predictor sees them
    q16_t limits [NUM_CFG];

    command_t    pending_cmds [$];
    logic [63:0] expected_frames [$];
    int          idle_pct;
    int          stall_pct;
    bit          failed = 1'b0;
    int          cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp, offset, scale by full scale, divide by span, truncate
    function automatic logic [15:0] quantize_code(q16_t x, q16_t lo, q16_t hi, int bits);
        longint span;
        longint val;
        longint unsigned full;
        longint unsigned prod;
        span = longint'(hi) - longint'(lo);
        full = (64'd1 << bits) - 1;
        val  = longint'(x);
        if (span <= 0)
            return 16'd0;
        if (val < longint'(lo))
            val = longint'(lo);
        if (val > longint'(hi))
            val = longint'(hi);
        prod = longint'(val - longint'(lo)) * full;
        return 16'(prod / longint'(span));
    endfunction

    function automatic logic [63:0] pack_frame(command_t c);
        logic [15:0] p, v, t, kp, kd;
        p  = quantize_code(c.position, limits[REG_POSITION_MIN], limits[REG_POSITION_MAX],
                           POS_BITS);
        v  = quantize_code(c.velocity, limits[REG_VELOCITY_MIN], limits[REG_VELOCITY_MAX],
                           GAIN_BITS);
        t  = quantize_code(c.torque, limits[REG_TORQUE_MIN], limits[REG_TORQUE_MAX],
                           GAIN_BITS);
        kp = quantize_code(c.stiffness_gain, STIFFNESS_MIN, limits[REG_STIFFNESS_MAX],
                           GAIN_BITS);
        kd = quantize_code(c.damping_gain, DAMPING_MIN, limits[REG_DAMPING_MAX], GAIN_BITS);
        return {p, v[11:0], kp[11:0], kd[11:0], t[11:0]};
    endfunction

    // Driver: present the head of the pending queue, advance on each transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            m_tready <= 1'b0;
        end
        else
        begin
            logic hs;
            int   n;
            hs = s_tvalid && s_tready;
            n  = pending_cmds.size();
            if (hs)
            begin
                expected_frames.push_back(pack_frame(pending_cmds[0]));
                void'(pending_cmds.pop_front());
                n = n - 1;
            end
            // Hold valid while an item is offered and not taken
            if (s_tvalid && !hs)
                s_tvalid <= 1'b1;
            else if (n > 0 && $urandom_range(99) >= idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_cmds[0];
            end
            else
                s_tvalid <= 1'b0;
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: compare every frame with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t: unexpected frame, expected none, actual %h", $time, m_tdata);
                failed = 1'b1;
            end
            else
            begin
                if (m_tdata !== expected_frames[0])
                begin
                    $display("%0t: frame mismatch, expected %h, actual %h",
                             $time, expected_frames[0], m_tdata);
                    failed = 1'b1;
                end
                void'(expected_frames.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_limit(logic [2:0] idx, q16_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limits[idx] = value;
    endtask

    task automatic drain;
        wait (pending_cmds.size() == 0 && !s_tvalid && expected_frames.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic q16_t rand_value();
        case ($urandom_range(5))
            0: return q16_t'($urandom);
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            2: return q16_t'($urandom_range(200)) - 32'sd100;
            default: return q16_t'($urandom_range(8000000)) - 32'sd4000000;
        endcase
    endfunction

    function automatic command_t rand_cmd();
        command_t c;
        c.position       = rand_value();
        c.velocity       = rand_value();
        c.torque         = rand_value();
        c.stiffness_gain = q16_t'($urandom_range(3) == 0 ? rand_value()
                                  : $urandom_range(33000000));
        c.damping_gain   = q16_t'($urandom_range(3) == 0 ? rand_value()
                                  : $urandom_range(340000));
        return c;
    endfunction

    function automatic command_t same_cmd(q16_t v);
        command_t c;
        c = '{v, v, v, v, v};
        return c;
    endfunction

    // Pick limits: random, full-width extremes, or an empty/inverted range
    task automatic random_limits(int mode);
        q16_t a, b;
        for (int i = 0; i < NUM_CFG; i += 2)
        begin
            a = rand_value();
            b = rand_value();
            if (mode == 1)
            begin
                a = 32'sh80000000;
                b = 32'sh7fffffff;
            end
            else if (mode == 2)
                b = a - q16_t'($urandom_range(1));
            else if (a > b)
            begin
                q16_t tmp;
                tmp = a; a = b; b = tmp;
            end
            if (i < 6)
            begin
                write_limit(3'(i), a);
                write_limit(3'(i + 1), b);
            end
            else
            begin
                write_limit(REG_STIFFNESS_MAX, mode == 1 ? 32'sh7fffffff : b);
                write_limit(REG_DAMPING_MAX, mode == 2 ? (q16_t'($urandom_range(1)) - 1) : b);
            end
        end
    endtask

    task automatic run_phase(int count, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
            pending_cmds.push_back(rand_cmd());
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        for (int i = 0; i < NUM_CFG; i++)
            limits[i] = CFG_RESET[i];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: range ends, out-of-range clamps, field extremes
        pending_cmds.push_back(same_cmd(32'sh80000000));
        pending_cmds.push_back(same_cmd(32'sh7fffffff));
        pending_cmds.push_back(same_cmd(32'sd0));
        pending_cmds.push_back(same_cmd(-32'sd1));
        pending_cmds.push_back('{32'sd327680, 32'sd32768000, 32'sd1179648,
                                 32'sd4259840, 32'sd819200});
        pending_cmds.push_back('{32'sd0, 32'sd0, -32'sd1179648, -32'sd4259840,
                                 -32'sd819200});
        pending_cmds.push_back('{32'sd327679, 32'sd32767999, 32'sd1179647,
                                 32'sd4259839, 32'sd819199});
        pending_cmds.push_back('{32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
                                 32'shaaaaaaaa, 32'sh55555555});
        drain();

        // Widest span, then empty and inverted ranges
        random_limits(1);
        pending_cmds.push_back(same_cmd(32'sh80000000));
        pending_cmds.push_back(same_cmd(32'sh7fffffff));
        pending_cmds.push_back(same_cmd(32'sd1));
        pending_cmds.push_back('{32'sh40000000, 32'sh40000000, 32'shc0000000,
                                 32'sh12345678, 32'shedcba987});
        drain();
        random_limits(2);
        pending_cmds.push_back(same_cmd(32'sd0));
        pending_cmds.push_back(same_cmd(32'sh7fffffff));
        pending_cmds.push_back(same_cmd(32'sh80000000));
        drain();

        // Random phases over several limit settings and idling patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: random_limits(0);
                1: random_limits($urandom_range(3) == 0 ? 1 : 0);
                2: random_limits($urandom_range(2) == 0 ? 2 : 0);
                default: for (int i = 0; i < NUM_CFG; i++) write_limit(3'(i), CFG_RESET[i]);
            endcase
            case (ph % 4)
                0: run_phase(140, 0, 0);
                1: run_phase(140, 71, 0);
                2: run_phase(140, 0, 71);
                default: run_phase(140, 9, 9);
            endcase
        end

        if (failed)
            $display("Some tests failed");
        else
            $display("All tests passed");
        $finish;
    end

endmodule
